// ===== sv/mscfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mscfd_pkg
// Shared types, constants and CRC-32 helpers for the frame deframer.
// ----------------------------------------------------------------------------
package mscfd_pkg;

  localparam int HdrLen = 13;
  localparam logic [3:0] HdrFull = 4'd13;
  localparam logic [3:0] HdrLast = 4'd12;
  localparam logic [12:0] CrcBytes = 13'd4;
  localparam logic [12:0] MaxPayload = 13'd4096;
  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

  typedef enum logic [1:0] {
    RegMagic   = 2'd0,
    RegVersion = 2'd1,
    RegMaxLen  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [7:0]  protocol_version;
    logic [12:0] max_payload_len;
  } cfg_t;

  typedef logic [31:0] crc_tab_t [256];

  // One reflected CRC-32 byte step: eight shift and conditional XOR steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

  // CRC register after thirteen zero bytes starting from all ones. Since the
  // CRC is linear, the header CRC is this constant XOR the CRC of the header
  // bytes taken from a zero start.
  function automatic logic [31:0] gen_init_term();
    logic [31:0] c;
    c = CrcInit;
    for (int i = 0; i < HdrLen; i++) begin
      c = crc_byte(c, 8'd0);
    end
    return c;
  endfunction

  // Contribution of a byte that has fallen out of the window: the byte
  // followed by thirteen zero bytes, from a zero start.
  function automatic crc_tab_t gen_drop_table();
    crc_tab_t t;
    logic [31:0] c;
    for (int b = 0; b < 256; b++) begin
      c = crc_byte(32'd0, b[7:0]);
      for (int i = 0; i < HdrLen; i++) begin
        c = crc_byte(c, 8'd0);
      end
      t[b] = c;
    end
    return t;
  endfunction

  localparam logic [31:0] InitTerm = gen_init_term();
  localparam crc_tab_t DropTable = gen_drop_table();

endpackage
`default_nettype wire

// ===== sv/mscfd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mscfd stream interfaces
// Byte input channel and result channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface mscfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface mscfd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [15:0] command;
  logic [15:0] sequence_res;
  logic [12:0] payload_length;
  logic        crc_ok;

  modport source (
    output valid, output kind, output payload_byte, output command,
    output sequence_res, output payload_length, output crc_ok, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input command,
    input sequence_res, input payload_length, input crc_ok, output ready
  );
endinterface
`default_nettype wire

// ===== sv/mscfd_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mscfd_regs
// APB-style configuration registers: magic word, version and length limit.
// ----------------------------------------------------------------------------
module mscfd_regs (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output mscfd_pkg::cfg_t       cfg_o
);
  import mscfd_pkg::*;

  logic [31:0] magic_q;
  logic [7:0]  version_q;
  logic [12:0] max_len_q;
  logic        wr_en;
  reg_idx_e    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= 32'd0;
      version_q <= 8'd0;
      max_len_q <= MaxPayload;
    end else if (wr_en) begin
      unique case (idx)
        RegMagic:   magic_q   <= pwdata;
        RegVersion: version_q <= pwdata[7:0];
        RegMaxLen:  max_len_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegMagic:   prdata = magic_q;
      RegVersion: prdata = {24'd0, version_q};
      RegMaxLen:  prdata = {19'd0, max_len_q};
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg_o.magic_word       = magic_q;
  assign cfg_o.protocol_version = version_q;
  assign cfg_o.max_payload_len  = max_len_q;

endmodule
`default_nettype wire

// ===== sv/mscfd_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mscfd_core
// Input register, header hunt with rolling CRC, body tracking and result
// register.
// ----------------------------------------------------------------------------
module mscfd_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  mscfd_pkg::cfg_t cfg_i,
  mscfd_in_if.sink        in_i,
  mscfd_out_if.source     out_o
);
  import mscfd_pkg::*;

  // Input register.
  logic        s1_vld_q, s1_vld_d;
  logic [7:0]  s1_byte_q;

  // Frame state. While hunting, crc_q holds the CRC of the held window bytes
  // from a zero start; in the body it holds the running frame CRC.
  logic [7:0]  win_q [HdrLen];
  logic [7:0]  win_n [HdrLen];
  logic [3:0]  held_q, held_d;
  logic        body_q, body_d;
  logic [12:0] left_q, left_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] rcv_q, rcv_d;
  logic [15:0] cmd_q, cmd_d;
  logic [15:0] seq_q, seq_d;
  logic [12:0] plen_q, plen_d;

  // Result register.
  logic        o_vld_q, o_vld_d;
  logic        o_kind_q;
  logic [7:0]  o_byte_q;
  logic [15:0] o_cmd_q;
  logic [15:0] o_seq_q;
  logic [12:0] o_plen_q;
  logic        o_ok_q;

  logic [7:0]  b;
  logic [31:0] crc_upd;
  logic [31:0] roll;
  logic [31:0] rcv_n;
  logic [31:0] plen32;
  logic [12:0] limit;
  logic        is_payload;
  logic        is_end;
  logic        res_gen;
  logic        good;
  logic        advance;

  assign b       = s1_byte_q;
  assign crc_upd = crc_byte(crc_q, b);
  assign roll    = crc_upd ^ ((held_q == HdrFull) ? DropTable[win_q[0]] : 32'd0);
  assign rcv_n   = {b, rcv_q[31:8]};

  always_comb begin
    for (int i = 0; i < HdrLen - 1; i++) begin
      win_n[i] = win_q[i + 1];
    end
    win_n[HdrLen - 1] = b;
  end

  assign plen32 = {win_n[12], win_n[11], win_n[10], win_n[9]};
  assign limit  = (cfg_i.max_payload_len > MaxPayload) ? MaxPayload : cfg_i.max_payload_len;
  assign good   = ({win_n[3], win_n[2], win_n[1], win_n[0]} == cfg_i.magic_word)
               && (win_n[4] == cfg_i.protocol_version)
               && (plen32 <= {19'd0, limit});

  assign is_payload = body_q && (left_q > CrcBytes);
  assign is_end     = body_q && (left_q == 13'd1);
  assign res_gen    = is_payload || is_end;
  assign advance    = s1_vld_q && (!res_gen || !o_vld_q || out_o.ready);

  assign in_i.ready = !s1_vld_q || advance;

  always_comb begin
    s1_vld_d = advance ? 1'b0 : s1_vld_q;
    if (in_i.valid && in_i.ready) begin
      s1_vld_d = 1'b1;
    end
  end

  always_comb begin
    held_d = held_q;
    body_d = body_q;
    left_d = left_q;
    crc_d  = crc_q;
    rcv_d  = rcv_q;
    cmd_d  = cmd_q;
    seq_d  = seq_q;
    plen_d = plen_q;
    if (advance) begin
      if (body_q) begin
        if (is_payload) begin
          crc_d  = crc_upd;
          left_d = left_q - 13'd1;
        end else if (is_end) begin
          // Frame closed: restart the hunt with an empty window.
          held_d = 4'd0;
          body_d = 1'b0;
          left_d = 13'd0;
          crc_d  = 32'd0;
          rcv_d  = 32'd0;
        end else begin
          rcv_d  = rcv_n;
          left_d = left_q - 13'd1;
        end
      end else if (held_q >= HdrLast) begin
        if (good) begin
          held_d = 4'd0;
          body_d = 1'b1;
          crc_d  = roll ^ InitTerm;
          rcv_d  = 32'd0;
          left_d = plen32[12:0] + CrcBytes;
          cmd_d  = {win_n[6], win_n[5]};
          seq_d  = {win_n[8], win_n[7]};
          plen_d = plen32[12:0];
        end else begin
          // Rejected: the oldest byte drops out when the next one arrives.
          held_d = HdrFull;
          crc_d  = roll;
        end
      end else begin
        held_d = held_q + 4'd1;
        crc_d  = roll;
      end
    end
  end

  always_comb begin
    o_vld_d = o_vld_q;
    if (out_o.ready) begin
      o_vld_d = 1'b0;
    end
    if (advance && res_gen) begin
      o_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
      held_q   <= 4'd0;
      body_q   <= 1'b0;
      left_q   <= 13'd0;
      crc_q    <= 32'd0;
      rcv_q    <= 32'd0;
      cmd_q    <= 16'd0;
      seq_q    <= 16'd0;
      plen_q   <= 13'd0;
    end else begin
      s1_vld_q <= s1_vld_d;
      o_vld_q  <= o_vld_d;
      held_q   <= held_d;
      body_q   <= body_d;
      left_q   <= left_d;
      crc_q    <= crc_d;
      rcv_q    <= rcv_d;
      cmd_q    <= cmd_d;
      seq_q    <= seq_d;
      plen_q   <= plen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.in_byte;
    end
    if (advance && !body_q) begin
      win_q <= win_n;
    end
    if (advance && res_gen) begin
      o_kind_q <= is_end;
      o_byte_q <= is_end ? 8'd0 : b;
      o_cmd_q  <= cmd_q;
      o_seq_q  <= seq_q;
      o_plen_q <= plen_q;
      o_ok_q   <= is_end && ((~crc_q) == rcv_n);
    end
  end

  assign out_o.valid          = o_vld_q;
  assign out_o.kind           = o_kind_q;
  assign out_o.payload_byte   = o_byte_q;
  assign out_o.command        = o_cmd_q;
  assign out_o.sequence_res   = o_seq_q;
  assign out_o.payload_length = o_plen_q;
  assign out_o.crc_ok         = o_ok_q;

endmodule
`default_nettype wire

// ===== sv/magic_sync_crc_frame_deframer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A payload or end-of-frame result passes the input register and then the
// result register, and is offered straight from the result register.
// Throughput: one byte per cycle while the result side takes results; the
// rolling CRC step and header check fit between input and result registers.
// Reset: asynchronous, active low; the deframer comes up hunting with an
// empty header window and the limit register at 4096.
// ----------------------------------------------------------------------------
// magic_sync_crc_frame_deframer_core
// Top level of the length-prefixed frame deframer with magic-word sync and
// CRC-32 check.
// ----------------------------------------------------------------------------
//
// The incoming byte stream slides through a 13-byte header window. Each time
// the window is full, it is checked against the magic word, the protocol
// version and the payload limit. While the check fails, the window slides by
// one byte per request.
//
// The CRC of the window is kept rolling while hunting, so no burst of CRC
// work is needed when a header is accepted: each new byte is folded in, and
// the byte that drops out of the window is removed with a constant table
// entry. On acceptance, a constant term for the all-ones start value is
// XORed in, giving the true CRC over the header.
//
// In the body, payload bytes are forwarded as results while the CRC runs.
// The four trailing CRC bytes give no result until the last, which produces
// the end-of-frame result with the match flag. A frame with a bad CRC is
// still closed, and the hunt restarts with an empty window.
//
// The result register lets the next request enter while a result waits.
// ----------------------------------------------------------------------------
module magic_sync_crc_frame_deframer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  mscfd_in_if.sink         in_i,
  mscfd_out_if.source      out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import mscfd_pkg::*;

  cfg_t cfg;

  mscfd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mscfd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

// ===== tb/sv/magic_sync_crc_frame_deframer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magic_sync_crc_frame_deframer_core_tb
// Self-checking bench for the frame deframer. A byte stream of good frames,
// frames with a bad CRC, broken headers, cut-off frames and line noise is
// driven through the input channel. A behavioral copy of the deframer
// predicts every payload and end-of-frame result, and a scoreboard checks
// them in order. The run steps through several register settings and
// several handshake pressure patterns.
// ----------------------------------------------------------------------------
module magic_sync_crc_frame_deframer_core_tb;
  import mscfd_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mscfd_in_if  in_if ();
  mscfd_out_if out_if ();

  magic_sync_crc_frame_deframer_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] command;
    logic [15:0] sequence_res;
    logic [12:0] payload_length;
    logic        crc_ok;
  } deframe_result_t;

  // Behavioral deframer plus the ordered list of results it still owes.
  class FrameScoreboard;
    logic [31:0] magic_word;
    logic [7:0]  version;
    logic [12:0] max_len;
    logic [7:0]  window [HdrLen];
    int unsigned fill;
    bit          in_body;
    int unsigned bytes_left;
    logic [31:0] run_crc;
    logic [31:0] rx_crc;
    logic [15:0] cur_cmd;
    logic [15:0] cur_seq;
    logic [12:0] cur_len;
    deframe_result_t owed_q [$];
    int unsigned errors;
    int unsigned payload_seen;
    int unsigned frames_seen;
    int unsigned bad_frames;

    function new();
      magic_word   = '0;
      version      = '0;
      max_len      = MaxPayload;
      cur_cmd      = '0;
      cur_seq      = '0;
      cur_len      = '0;
      errors       = 0;
      payload_seen = 0;
      frames_seen  = 0;
      bad_frames   = 0;
      restart_hunt();
    endfunction

    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
        r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
      end
      return r;
    endfunction

    function void restart_hunt();
      foreach (window[i]) window[i] = '0;
      fill       = 0;
      in_body    = 1'b0;
      bytes_left = 0;
      run_crc    = CrcInit;
      rx_crc     = '0;
    endfunction

    // A rejected header drops its oldest byte only.
    function void slide();
      for (int i = 0; i < HdrLen - 1; i++) window[i] = window[i + 1];
      window[HdrLen - 1] = '0;
      fill = HdrLen - 1;
    endfunction

    function void write_reg(int unsigned idx, logic [31:0] v);
      case (idx)
        RegMagic:   magic_word = v;
        RegVersion: version = v[7:0];
        RegMaxLen:  max_len = v[12:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      int unsigned pos;
      int unsigned limit;
      int unsigned plen;
      bit          good;
      if (in_body) begin
        if (bytes_left > CrcBytes) begin
          run_crc = crc_step(run_crc, b);
          bytes_left--;
          payload_seen++;
          owed_q.push_back('{1'b0, b, cur_cmd, cur_seq, cur_len, 1'b0});
        end else begin
          pos    = (4 - bytes_left) & 3;
          rx_crc = rx_crc | (32'(b) << (8 * pos));
          if (bytes_left > 1) begin
            bytes_left--;
            return;
          end
          good = ((~run_crc) == rx_crc);
          frames_seen++;
          if (!good) bad_frames++;
          owed_q.push_back('{1'b1, 8'd0, cur_cmd, cur_seq, cur_len, good});
          restart_hunt();
        end
        return;
      end
      window[fill] = b;
      fill++;
      if (fill < HdrLen) return;
      limit = (max_len < MaxPayload) ? max_len : MaxPayload;
      plen  = {window[12], window[11], window[10], window[9]};
      good  = ({window[3], window[2], window[1], window[0]} == magic_word) &&
              (window[4] == version) && (plen <= limit);
      if (!good) begin
        slide();
        return;
      end
      cur_cmd = {window[6], window[5]};
      cur_seq = {window[8], window[7]};
      cur_len = plen[12:0];
      run_crc = CrcInit;
      foreach (window[i]) run_crc = crc_step(run_crc, window[i]);
      rx_crc     = '0;
      bytes_left = plen + CrcBytes;
      in_body    = 1'b1;
      fill       = 0;
    endfunction

    function void report_field(string name, logic [31:0] e, logic [31:0] a);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
    endfunction

    function void check_result(deframe_result_t act);
      deframe_result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed, expected none, actual %p", $time, act);
        return;
      end
      want = owed_q.pop_front();
      if (act.kind !== want.kind) report_field("kind", want.kind, act.kind);
      if (act.payload_byte !== want.payload_byte)
        report_field("payload_byte", want.payload_byte, act.payload_byte);
      if (act.command !== want.command) report_field("command", want.command, act.command);
      if (act.sequence_res !== want.sequence_res)
        report_field("sequence_res", want.sequence_res, act.sequence_res);
      if (act.payload_length !== want.payload_length)
        report_field("payload_length", want.payload_length, act.payload_length);
      if (act.crc_ok !== want.crc_ok) report_field("crc_ok", want.crc_ok, act.crc_ok);
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  FrameScoreboard sb = new();

  // Bytes waiting to be offered, and the handshake pressure of this phase.
  logic [7:0]  byte_q [$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  bit          offering = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycles = 0;

  // Bench copy of the registers, used to build matching frames.
  logic [31:0] cur_magic = '0;
  logic [7:0]  cur_version = '0;
  logic [12:0] cur_max = MaxPayload;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The run never takes this long when the block works.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results still owed", cycles, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Input driver: once a request is offered it stays up until it is taken;
  // otherwise the next byte is offered unless this cycle is an idle one.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!offering) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid   <= 1'b1;
        in_if.in_byte <= byte_q.pop_front();
        offering = 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Both channels are sampled at the rising edge, where the handshakes land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_byte(in_if.in_byte);
        bytes_taken++;
        offering = 1'b0;
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_result('{out_if.kind, out_if.payload_byte, out_if.command,
                          out_if.sequence_res, out_if.payload_length, out_if.crc_ok});
      end
    end
  end

  function automatic int unsigned cur_limit();
    return (cur_max < MaxPayload) ? cur_max : MaxPayload;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    byte_q.push_back(b);
    bytes_queued++;
  endtask

  // Register write over the APB port, followed by a read-back of the
  // registers that exist. Only called while the deframer is idle.
  task automatic config_reg(input int unsigned idx, input logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] rd;
    case (idx)
      RegMagic: begin
        mask = 32'hFFFF_FFFF;
        cur_magic = val;
      end
      RegVersion: begin
        mask = 32'h0000_00FF;
        cur_version = val[7:0];
      end
      RegMaxLen: begin
        mask = 32'h0000_1FFF;
        cur_max = val[12:0];
      end
      default: mask = '0;
    endcase
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx * 4);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (mask == '0) begin
      psel <= 1'b0;
    end else begin
      // psel stays high: this cycle is the setup cycle of the read.
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      rd = prdata;
      if (rd !== (val & mask)) sb.report_field("register read-back", val & mask, rd);
      @(negedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // One frame: header, pay_count payload bytes and, if asked, the CRC,
  // optionally with one bit flipped. hdr_len need not match pay_count.
  task automatic queue_frame(input logic [31:0] magic, input logic [7:0] ver,
                             input logic [15:0] cmd, input logic [15:0] seq,
                             input logic [31:0] hdr_len, input int unsigned pay_count,
                             input bit add_crc, input bit corrupt);
    logic [7:0]  hdr [HdrLen];
    logic [31:0] crc;
    logic [7:0]  b;
    hdr = '{magic[7:0], magic[15:8], magic[23:16], magic[31:24], ver,
            cmd[7:0], cmd[15:8], seq[7:0], seq[15:8],
            hdr_len[7:0], hdr_len[15:8], hdr_len[23:16], hdr_len[31:24]};
    crc = CrcInit;
    foreach (hdr[i]) begin
      crc = FrameScoreboard::crc_step(crc, hdr[i]);
      push_byte(hdr[i]);
    end
    repeat (pay_count) begin
      b   = 8'($urandom);
      crc = FrameScoreboard::crc_step(crc, b);
      push_byte(b);
    end
    if (add_crc) begin
      crc = ~crc;
      if (corrupt) crc = crc ^ (32'd1 << $urandom_range(31));
      for (int k = 0; k < 4; k++) push_byte(crc[8 * k +: 8]);
    end
  endtask

  // Mostly well-formed frames with random content; the rest are broken
  // headers, oversized lengths, cut-off bodies and noise with partial sync.
  task automatic random_units(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned r;
    int unsigned lim;
    int unsigned plen;
    logic [31:0] mag;
    logic [7:0]  ver;
    logic [31:0] big_len;
    stop_at = bytes_queued + n_bytes;
    lim = cur_limit();
    while (bytes_queued < stop_at) begin
      r = $urandom_range(99);
      if ($urandom_range(9) == 0) plen = $urandom_range(lim < 200 ? lim : 200);
      else plen = $urandom_range(lim < 24 ? lim : 24);
      if (r < 72) begin
        queue_frame(cur_magic, cur_version, 16'($urandom), 16'($urandom), plen, plen,
                    1'b1, $urandom_range(4) == 0);
      end else if (r < 80) begin
        mag = cur_magic;
        ver = cur_version;
        if ($urandom_range(1) == 0) mag = mag ^ (32'd1 << $urandom_range(31));
        else ver = ver ^ (8'd1 << $urandom_range(7));
        queue_frame(mag, ver, 16'($urandom), 16'($urandom), plen, plen, 1'b1, 1'b0);
      end else if (r < 86) begin
        if ($urandom_range(1) == 0) big_len = lim + 1 + $urandom_range(3);
        else big_len = $urandom | 32'h0001_0000;
        queue_frame(cur_magic, cur_version, 16'($urandom), 16'($urandom), big_len,
                    $urandom_range(6), 1'b0, 1'b0);
      end else if (r < 92) begin
        // The body is cut short, so the next bytes are taken as its tail.
        queue_frame(cur_magic, cur_version, 16'($urandom), 16'($urandom), plen,
                    $urandom_range(plen), 1'b0, 1'b0);
      end else begin
        for (int k = $urandom_range(3); k < 4; k++) push_byte(cur_magic[8 * k +: 8]);
        repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
      end
    end
  endtask

  // Waits until every byte is taken and every owed result has come, then
  // gives bytes that cause no result time to clear the pipeline.
  task automatic drain();
    while (byte_q.size() != 0 || offering) @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    out_if.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Phase one: no idling on either side.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    config_reg(RegMagic, 32'h5AA5_C33C);
    config_reg(RegVersion, 32'h01);
    config_reg(RegMaxLen, MaxPayload);
    // Noise at both byte extremes, then a sync that breaks off after three bytes.
    push_byte(8'h00);
    push_byte(8'hFF);
    for (int k = 0; k < 3; k++) push_byte(cur_magic[8 * k +: 8]);
    // A frame with an empty payload, then a one-byte frame with a bad CRC.
    queue_frame(cur_magic, cur_version, 16'hFFFF, 16'h0000, 0, 0, 1'b1, 1'b0);
    queue_frame(cur_magic, cur_version, 16'h0000, 16'hFFFF, 1, 1, 1'b1, 1'b1);
    drain();
    // A register value above the payload range is clamped to 4096, so a
    // header one past that is rejected.
    config_reg(RegMaxLen, 32'h1FFF);
    queue_frame(cur_magic, cur_version, 16'($urandom), 16'($urandom), MaxPayload + 1, 0,
                1'b0, 1'b0);
    random_units(100);
    drain();

    // Phase two: the sender idles about half the time; only empty payloads.
    send_idle_pct  = 51;
    recv_stall_pct = 0;
    config_reg(RegMagic, 32'hFFFF_FFFF);
    config_reg(RegVersion, 32'hFF);
    config_reg(RegMaxLen, 32'h0);
    queue_frame(cur_magic, cur_version, 16'($urandom), 16'($urandom), 1, 1, 1'b1, 1'b0);
    queue_frame(cur_magic, cur_version, 16'($urandom), 16'($urandom), 0, 0, 1'b1, 1'b0);
    random_units(100);
    drain();

    // Phase three: the receiver stalls about half the time; a small limit.
    send_idle_pct  = 0;
    recv_stall_pct = 51;
    config_reg(RegMagic, 32'h0);
    config_reg(RegVersion, 32'h0);
    config_reg(RegMaxLen, $urandom_range(1, 40));
    // No register lies at the next address, so this write changes nothing.
    config_reg(3, $urandom);
    queue_frame(cur_magic, cur_version, 16'($urandom), 16'($urandom), cur_limit(),
                cur_limit(), 1'b1, 1'b0);
    random_units(100);
    drain();

    // Phase four: both sides idle; random sync, version and a clamped limit.
    send_idle_pct  = 32;
    recv_stall_pct = 32;
    config_reg(RegMagic, $urandom);
    config_reg(RegVersion, $urandom_range(255));
    config_reg(RegMaxLen, $urandom_range(MaxPayload + 1, 8191));
    random_units(50);
    // The sender holds off here until the result side has caught up.
    drain();
    random_units(50);
    drain();

    $display("Covered %0d bytes in four handshake phases: %0d payload bytes, %0d frames",
             bytes_taken, sb.payload_seen, sb.frames_seen);
    $display("closed (%0d with a bad CRC), under %0d cycles of run time", sb.bad_frames,
             cycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mscfd_pkg.sv
sv/mscfd_if.sv
sv/mscfd_regs.sv
sv/mscfd_core.sv
sv/magic_sync_crc_frame_deframer_core.sv
tb/sv/magic_sync_crc_frame_deframer_core_tb.sv
